[design/rotation_matrix_to_euler_angles_core_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the rotation matrix to Euler core.
// ---------------------------------------------------------------------------
`ifndef ROTATION_MATRIX_TO_EULER_ANGLES_CORE_ASSERT_SVH
`define ROTATION_MATRIX_TO_EULER_ANGLES_CORE_ASSERT_SVH

// same-cycle implication
`define R2E_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication
`define R2E_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

[design/r2e_pkg.sv]
// ---------------------------------------------------------------------------
// r2e_pkg
// Types, constants and helper functions of the rotation matrix to Euler core.
// ---------------------------------------------------------------------------
package r2e_pkg;

	localparam int EW    = 16;
	localparam int SH    = 30 - EW;
	localparam int VW    = 31;
	localparam int CW    = 34;
	localparam int AW    = 26;
	localparam int OW    = 16;
	localparam int TW    = 11;
	localparam int RB    = 30;
	localparam int RW    = 60;
	localparam int STEPS = 16;
	localparam int LANES = 3;

	localparam int HALF_TURN    = 23040;
	localparam int QUARTER_TURN = 11520;
	localparam int ACC_HALF     = 180 * 32768;

	localparam logic REG_TOL = 1'b0;
	localparam logic [TW-1:0] TOL_RESET = TW'(1);

	typedef logic signed [EW-1:0] ent_t;
	typedef logic signed [OW-1:0] ang_t;
	typedef logic signed [VW-1:0] val_t;
	typedef logic signed [CW-1:0] cval_t;
	typedef logic signed [AW-1:0] acc_t;

	typedef struct packed {
		cval_t x;
		cval_t y;
		acc_t  acc;
		logic  spec;
		ang_t  specv;
	} cordic_t;

	typedef struct packed {
		logic [RW-1:0] rem;
		logic [RB-1:0] root;
	} sqrt_t;

	typedef struct packed {
		val_t py;
		val_t fx;
		val_t fy;
		val_t tx;
		val_t ty;
		logic sing;
		logic neg;
	} side_t;

	typedef struct packed {
		logic sing;
		logic neg;
	} flags_t;

	function automatic acc_t atan_tab(input logic [4:0] s);
		acc_t r;
		case (s)
			5'd0:  r = AW'(1474560);
			5'd1:  r = AW'(870484);
			5'd2:  r = AW'(459940);
			5'd3:  r = AW'(233473);
			5'd4:  r = AW'(117189);
			5'd5:  r = AW'(58652);
			5'd6:  r = AW'(29333);
			5'd7:  r = AW'(14667);
			5'd8:  r = AW'(7334);
			5'd9:  r = AW'(3667);
			5'd10: r = AW'(1833);
			5'd11: r = AW'(917);
			5'd12: r = AW'(458);
			5'd13: r = AW'(229);
			5'd14: r = AW'(115);
			5'd15: r = AW'(57);
			5'd16: r = AW'(29);
			5'd17: r = AW'(14);
			5'd18: r = AW'(7);
			5'd19: r = AW'(4);
			5'd20: r = AW'(2);
			5'd21: r = AW'(1);
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic cordic_t atan_prep(input val_t y, input val_t x);
		cordic_t c;
		c.x     = CW'(x);
		c.y     = CW'(y);
		c.acc   = '0;
		c.spec  = 1'b0;
		c.specv = '0;
		if (y == '0) begin
			c.spec  = 1'b1;
			c.specv = (x < 0) ? OW'(HALF_TURN) : '0;
		end else if (x == '0) begin
			c.spec  = 1'b1;
			c.specv = (y > 0) ? OW'(QUARTER_TURN) : -OW'(QUARTER_TURN);
		end else if (x < 0) begin
			c.acc = (y > 0) ? AW'(ACC_HALF) : -AW'(ACC_HALF);
			c.x   = -c.x;
			c.y   = -c.y;
		end
		return c;
	endfunction

	function automatic ang_t atan_fin(input cordic_t c);
		acc_t sum;
		logic signed [AW-9:0] r;
		ang_t a;
		sum = c.acc + AW'(128);
		r   = (AW-8)'(sum >>> 8);
		if (r > (AW-8)'(HALF_TURN)) begin
			a = OW'(HALF_TURN);
		end else if (r < -(AW-8)'(HALF_TURN)) begin
			a = -OW'(HALF_TURN);
		end else begin
			a = OW'(r);
		end
		return c.spec ? c.specv : a;
	endfunction

	function automatic ang_t snap(input ang_t d, input logic [TW-1:0] tol);
		logic signed [18:0] e;
		logic signed [18:0] t;
		logic signed [18:0] tg [5];
		ang_t r;
		logic hit;
		e = 19'(d);
		t = 19'({1'b0, tol});
		tg[0] = '0;
		tg[1] = 19'(HALF_TURN);
		tg[2] = 19'(2 * HALF_TURN);
		tg[3] = -19'(HALF_TURN);
		tg[4] = -19'(2 * HALF_TURN);
		r = d;
		hit = 1'b0;
		for (int k = 0; k < 5; k++) begin
			if (!hit && (tg[k] - t < e) && (e < tg[k] + t)) begin
				r = OW'(tg[k]);
				hit = 1'b1;
			end
		end
		return r;
	endfunction

endpackage

[design/r2e_sqrt_cell.sv]
// ---------------------------------------------------------------------------
// r2e_sqrt_cell
// One digit of the integer square root: trial subtract and root bit decide.
// ---------------------------------------------------------------------------
module r2e_sqrt_cell (
	input  logic            clk,
	input  logic            advance,
	input  logic [4:0]      step,
	input  r2e_pkg::sqrt_t  d_in,
	output r2e_pkg::sqrt_t  d_out
);
	import r2e_pkg::*;

	logic [4:0]  b;
	logic [RW:0] trial;
	sqrt_t       nxt;

	always_comb begin
		b     = 5'(RB - 1) - step;
		trial = ((RW+1)'(d_in.root) << (b + 5'd1)) + ((RW+1)'(1) << {b, 1'b0});
		nxt   = d_in;
		if ({1'b0, d_in.rem} >= trial) begin
			nxt.rem  = d_in.rem - trial[RW-1:0];
			nxt.root = d_in.root | (RB'(1) << b);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			d_out <= nxt;
		end
	end

endmodule

[design/r2e_cordic_cell.sv]
// ---------------------------------------------------------------------------
// r2e_cordic_cell
// One vectoring CORDIC micro-rotation with its angle accumulator.
// ---------------------------------------------------------------------------
module r2e_cordic_cell (
	input  logic              clk,
	input  logic              advance,
	input  logic [4:0]        step,
	input  r2e_pkg::cordic_t  d_in,
	output r2e_pkg::cordic_t  d_out
);
	import r2e_pkg::*;

	cval_t   xs;
	cval_t   ys;
	cordic_t nxt;

	always_comb begin
		xs  = d_in.x >>> step;
		ys  = d_in.y >>> step;
		nxt = d_in;
		if (d_in.y >= 0) begin
			nxt.x   = d_in.x + ys;
			nxt.y   = d_in.y - xs;
			nxt.acc = d_in.acc + atan_tab(step);
		end else begin
			nxt.x   = d_in.x - ys;
			nxt.y   = d_in.y + xs;
			nxt.acc = d_in.acc - atan_tab(step);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			d_out <= nxt;
		end
	end

endmodule

[design/rotation_matrix_to_euler_angles_core.sv]
// ---------------------------------------------------------------------------
// rotation_matrix_to_euler_angles_core
// Z-Y-X Euler angles from a rotation matrix: square root and CORDIC cell rows.
// ---------------------------------------------------------------------------
// Throughput: one request per cycle; the 30-cell root row and 16-cell CORDIC
// rows each hand on one step per cycle, and the whole row holds on output stall.
// Reset: asynchronous, clears valid flags; snap_tolerance returns to 1.
module rotation_matrix_to_euler_angles_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  logic                in_valid,
	output logic                in_stall,
	input  r2e_pkg::ent_t       m_row1_col1,
	input  r2e_pkg::ent_t       m_row1_col2,
	input  r2e_pkg::ent_t       m_row2_col1,
	input  r2e_pkg::ent_t       m_row2_col2,
	input  r2e_pkg::ent_t       m_row3_col1,
	input  r2e_pkg::ent_t       m_row3_col2,
	input  r2e_pkg::ent_t       m_row3_col3,
	output logic                out_valid,
	input  logic                out_stall,
	output r2e_pkg::ang_t       angle_first,
	output r2e_pkg::ang_t       angle_pitch,
	output r2e_pkg::ang_t       angle_third,
	output logic                singular
);
	import r2e_pkg::*;

	`include "rotation_matrix_to_euler_angles_core_assert.svh"

	logic [TW-1:0] tol_q;
	logic          advance;
	logic          cfg_wr;

	ent_t m11_s1, m12_s1, m21_s1, m22_s1, m31_s1, m32_s1, m33_s1;
	logic v_s1, v_s2, v_s3, v_sf;
	logic [31:0] sq11_s2, sq21_s2, sum_s3;
	side_t side_s2, side_s3;

	sqrt_t  sq_in  [RB];
	sqrt_t  sq_out [RB];
	side_t  side_q [RB];
	logic [RB-1:0] v_sq;

	cordic_t cd_in  [LANES][STEPS];
	cordic_t cd_out [LANES][STEPS];
	flags_t  fl_q   [STEPS];
	logic [STEPS-1:0] v_cd;

	ang_t   first_sf, pitch_sf, third_sf;
	logic   sing_sf;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready && (paddr[2] == REG_TOL);
	assign prdata  = (paddr[2] == REG_TOL) ? 32'(tol_q) : '0;
	assign advance = !out_valid || !out_stall;
	assign in_stall = !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (cfg_wr) begin
			tol_q <= pwdata[TW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_sq      <= '0;
			v_cd      <= '0;
			v_sf      <= 1'b0;
			out_valid <= 1'b0;
		end else if (advance) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_sq      <= {v_sq[RB-2:0], v_s3};
			v_cd      <= {v_cd[STEPS-2:0], v_sq[RB-1]};
			v_sf      <= v_cd[STEPS-1];
			out_valid <= v_sf;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m11_s1 <= m_row1_col1;
			m12_s1 <= m_row1_col2;
			m21_s1 <= m_row2_col1;
			m22_s1 <= m_row2_col2;
			m31_s1 <= m_row3_col1;
			m32_s1 <= m_row3_col2;
			m33_s1 <= m_row3_col3;

			sq11_s2      <= 32'(m11_s1 * m11_s1);
			sq21_s2      <= 32'(m21_s1 * m21_s1);
			side_s2.sing <= (m11_s1 == '0) && (m21_s1 == '0) && (m31_s1 != '0);
			side_s2.neg  <= (m11_s1 == '0) && (m21_s1 == '0) && (m31_s1 > 0);
			side_s2.py   <= -(VW'(m31_s1) <<< SH);
			side_s2.fx   <= VW'(m11_s1) <<< SH;
			side_s2.fy   <= VW'(m21_s1) <<< SH;
			if ((m11_s1 == '0) && (m21_s1 == '0) && (m31_s1 != '0)) begin
				side_s2.tx <= VW'(m22_s1) <<< SH;
				side_s2.ty <= VW'(m12_s1) <<< SH;
			end else begin
				side_s2.tx <= VW'(m33_s1) <<< SH;
				side_s2.ty <= VW'(m32_s1) <<< SH;
			end

			sum_s3  <= sq11_s2 + sq21_s2;
			side_s3 <= side_s2;

			side_q[0] <= side_s3;
			for (int k = 1; k < RB; k++) begin
				side_q[k] <= side_q[k-1];
			end

			fl_q[0].sing <= side_q[RB-1].sing;
			fl_q[0].neg  <= side_q[RB-1].neg;
			for (int k = 1; k < STEPS; k++) begin
				fl_q[k] <= fl_q[k-1];
			end

			first_sf <= atan_fin(cd_out[0][STEPS-1]);
			pitch_sf <= atan_fin(cd_out[1][STEPS-1]);
			third_sf <= fl_q[STEPS-1].neg ? -atan_fin(cd_out[2][STEPS-1])
			                              : atan_fin(cd_out[2][STEPS-1]);
			sing_sf  <= fl_q[STEPS-1].sing;

			angle_first <= snap(first_sf, tol_q);
			angle_pitch <= snap(pitch_sf, tol_q);
			angle_third <= snap(third_sf, tol_q);
			singular    <= sing_sf;
		end
	end

	// sqrt radicand: scaled m11^2 + m21^2
	assign sq_in[0].rem  = RW'(sum_s3) << (2 * SH);
	assign sq_in[0].root = '0;

	genvar k, l;
	generate
		for (k = 0; k < RB; k++) begin : g_sqrt
			if (k > 0) begin : g_link
				assign sq_in[k] = sq_out[k-1];
			end
			r2e_sqrt_cell u_cell (
				.clk     (clk),
				.advance (advance),
				.step    (5'(k)),
				.d_in    (sq_in[k]),
				.d_out   (sq_out[k])
			);
		end

		assign cd_in[0][0] = atan_prep(side_q[RB-1].fy, side_q[RB-1].fx);
		assign cd_in[1][0] = atan_prep(side_q[RB-1].py, VW'({1'b0, sq_out[RB-1].root}));
		assign cd_in[2][0] = atan_prep(side_q[RB-1].ty, side_q[RB-1].tx);

		for (l = 0; l < LANES; l++) begin : g_lane
			for (k = 0; k < STEPS; k++) begin : g_step
				if (k > 0) begin : g_link
					assign cd_in[l][k] = cd_out[l][k-1];
				end
				r2e_cordic_cell u_cell (
					.clk     (clk),
					.advance (advance),
					.step    (5'(k)),
					.d_in    (cd_in[l][k]),
					.d_out   (cd_out[l][k])
				);
			end
		end
	endgenerate

	`R2E_ASSERT_SAME(a_hold_in, out_valid && out_stall, in_stall)
	`R2E_ASSERT_SAME(a_sing_first, out_valid && singular, angle_first == '0)
	`R2E_ASSERT_SAME(a_sing_pitch, out_valid && singular, (angle_pitch == OW'(QUARTER_TURN)) || (angle_pitch == -OW'(QUARTER_TURN)))
	`R2E_ASSERT_NEXT(a_cfg_write, cfg_wr, tol_q == $past(pwdata[TW-1:0]))

endmodule

[tb/euler_angle_checker.sv]
// ---------------------------------------------------------------------------
// euler_angle_checker
// Watches the matrix and angle channels, computes the Euler angles of every
// accepted request and compares them with the results the core returns.
// ---------------------------------------------------------------------------
module euler_angle_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	input  logic                in_valid,
	input  logic                in_stall,
	input  r2e_pkg::ent_t       m_row1_col1,
	input  r2e_pkg::ent_t       m_row1_col2,
	input  r2e_pkg::ent_t       m_row2_col1,
	input  r2e_pkg::ent_t       m_row2_col2,
	input  r2e_pkg::ent_t       m_row3_col1,
	input  r2e_pkg::ent_t       m_row3_col2,
	input  r2e_pkg::ent_t       m_row3_col3,
	input  logic                out_valid,
	input  logic                out_stall,
	input  r2e_pkg::ang_t       angle_first,
	input  r2e_pkg::ang_t       angle_pitch,
	input  r2e_pkg::ang_t       angle_third,
	input  logic                singular,
	output int                  fail_count,
	output int                  pending
);
	import r2e_pkg::*;

	typedef struct {
		ang_t first;
		ang_t pitch;
		ang_t third;
		logic sing;
	} euler_t;

	localparam int TAB [16] = '{1474560, 870484, 459940, 233473, 117189, 58652, 29333,
		14667, 7334, 3667, 1833, 917, 458, 229, 115, 57};

	euler_t angle_queue[$];
	logic [TW-1:0] tolerance;

	function automatic longint shr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint root_floor(longint n);
		longint r;
		longint b;
		r = 0;
		b = 64'sd1 <<< 62;
		while (b > n)
			b = b >>> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >>> 1) + b;
			end else begin
				r = r >>> 1;
			end
			b = b >>> 2;
		end
		return r;
	endfunction

	function automatic longint vector_angle(longint y, longint x);
		longint a;
		longint xs;
		longint ys;
		longint r;
		a = 0;
		if (y == 0)
			return (x < 0) ? HALF_TURN : 0;
		if (x == 0)
			return (y > 0) ? QUARTER_TURN : -QUARTER_TURN;
		if (x < 0) begin
			a = (y > 0) ? ACC_HALF : -ACC_HALF;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < STEPS; i++) begin
			xs = shr(x, i);
			ys = shr(y, i);
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				a = a + TAB[i];
			end else begin
				x = x - ys;
				y = y + xs;
				a = a - TAB[i];
			end
		end
		r = shr(a + 128, 8);
		if (r > HALF_TURN)
			r = HALF_TURN;
		if (r < -HALF_TURN)
			r = -HALF_TURN;
		return r;
	endfunction

	function automatic ang_t snapped(longint d);
		longint t;
		longint tg [5];
		t = tolerance;
		tg = '{0, HALF_TURN, 2 * HALF_TURN, -HALF_TURN, -2 * HALF_TURN};
		for (int k = 0; k < 5; k++)
			if (tg[k] - t < d && d < tg[k] + t)
				return ang_t'(tg[k]);
		return ang_t'(d);
	endfunction

	function automatic euler_t euler_of(longint m11, longint m12, longint m21,
		longint m22, longint m31, longint m32, longint m33);
		euler_t e;
		longint den;
		longint f;
		longint p;
		longint t;
		den = root_floor((m11 * m11 + m21 * m21) <<< (2 * SH));
		p = vector_angle(-m31 <<< SH, den);
		e.sing = (m11 == 0 && m21 == 0 && m31 != 0);
		if (e.sing) begin
			f = 0;
			t = vector_angle(m12 <<< SH, m22 <<< SH);
			if (m31 > 0)
				t = -t;
		end else begin
			f = vector_angle(m21 <<< SH, m11 <<< SH);
			t = vector_angle(m32 <<< SH, m33 <<< SH);
		end
		e.first = snapped(f);
		e.pitch = snapped(p);
		e.third = snapped(t);
		return e;
	endfunction

	assign pending = angle_queue.size();

	always @(posedge clk or negedge arst_n) begin
		euler_t e;
		if (!arst_n) begin
			tolerance <= TOL_RESET;
			fail_count <= 0;
			angle_queue.delete();
		end else begin
			if (psel && penable && pwrite && paddr == {REG_TOL, 2'b00})
				tolerance <= pwdata[TW-1:0];
			if (in_valid && !in_stall)
				angle_queue = {angle_queue, euler_of(m_row1_col1, m_row1_col2,
					m_row2_col1, m_row2_col2, m_row3_col1, m_row3_col2, m_row3_col3)};
			if (out_valid && !out_stall) begin
				if (angle_queue.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result at %0t", $realtime);
					fail_count <= fail_count + 1;
				end else begin
					e = angle_queue.pop_front();
					if (e.first !== angle_first || e.pitch !== angle_pitch
						|| e.third !== angle_third || e.sing !== singular) begin
						if (fail_count < 10)
							$display("mismatch: exp %0d %0d %0d %b got %0d %0d %0d %b",
								e.first, e.pitch, e.third, e.sing,
								angle_first, angle_pitch, angle_third, singular);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

[tb/rotation_matrix_to_euler_angles_core_tb.sv]
// ---------------------------------------------------------------------------
// rotation_matrix_to_euler_angles_core_tb
// Drives directed and random matrices through the core under several snap
// tolerances with random gaps and stalls; the checker grades every result.
// ---------------------------------------------------------------------------
module rotation_matrix_to_euler_angles_core_tb;
	import r2e_pkg::*;

	localparam int LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	ent_t m11 = '0, m12 = '0, m21 = '0, m22 = '0, m31 = '0, m32 = '0, m33 = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	ang_t angle_first, angle_pitch, angle_third;
	logic singular;
	int fail_count;
	int pending;
	int cycles = 0;
	int stall_left = 0;
	logic hold_off = 1'b0;

	always #1 clk = ~clk;

	rotation_matrix_to_euler_angles_core DUT (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.in_valid, .in_stall,
		.m_row1_col1(m11), .m_row1_col2(m12), .m_row2_col1(m21), .m_row2_col2(m22),
		.m_row3_col1(m31), .m_row3_col2(m32), .m_row3_col3(m33),
		.out_valid, .out_stall, .angle_first, .angle_pitch, .angle_third, .singular
	);

	euler_angle_checker checker_i (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
		.in_valid, .in_stall,
		.m_row1_col1(m11), .m_row1_col2(m12), .m_row2_col1(m21), .m_row2_col2(m22),
		.m_row3_col1(m31), .m_row3_col2(m32), .m_row3_col3(m33),
		.out_valid, .out_stall, .angle_first, .angle_pitch, .angle_third, .singular,
		.fail_count, .pending
	);

	function automatic int gap_len();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(10, 40);
		return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
	endfunction

	function automatic ent_t any_entry();
		case ($urandom_range(0, 5))
			0: return ent_t'(0);
			1: return ent_t'(16'h8000);
			2: return ent_t'(16'h7fff);
			3: return ent_t'($urandom_range(0, 16384));
			4: return -ent_t'($urandom_range(0, 16384));
			default: return ent_t'($urandom);
		endcase
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		int n;
		if (hold_off) begin
			out_stall <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (!out_stall || $urandom_range(0, 2) == 0) begin
			n = $urandom_range(0, 49);
			if (n == 0)
				stall_left <= $urandom_range(10, 40);
			out_stall <= (n < 10);
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic send(ent_t a, ent_t b, ent_t c, ent_t d, ent_t e, ent_t f, ent_t g);
		int n;
		n = gap_len();
		if (n != 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		in_valid <= 1'b1;
		m11 <= a; m12 <= b; m21 <= c; m22 <= d; m31 <= e; m32 <= f; m33 <= g;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic send_random(int count);
		real r, p, y;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 3) != 0) begin
				r = $urandom_range(0, 62831) / 10000.0;
				p = $urandom_range(0, 62831) / 10000.0;
				y = $urandom_range(0, 62831) / 10000.0;
				send(ent_t'($rtoi(16384.0 * $cos(r) * $cos(p))),
					ent_t'($rtoi(16384.0 * $cos(y))),
					ent_t'($rtoi(16384.0 * $sin(r) * $cos(p))),
					ent_t'($rtoi(16384.0 * $sin(y))),
					ent_t'($rtoi(-16384.0 * $sin(p))),
					ent_t'($rtoi(16384.0 * $sin(y) * $cos(p))),
					ent_t'($rtoi(16384.0 * $cos(y) * $cos(p))));
			end else begin
				send(any_entry(), any_entry(), any_entry(), any_entry(), any_entry(),
					any_entry(), any_entry());
			end
		end
	endtask

	task automatic write_tolerance(int value);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= {REG_TOL, 2'b00};
		pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send('0, '0, '0, '0, '0, '0, '0);
		send(16384, 0, 0, 16384, 0, 0, 16384);
		send(0, 16384, 0, 16384, 16384, 0, 0);
		send(0, -16384, 0, 16384, -16384, 0, 0);
		send(0, 5000, 0, -7000, 100, 3, 4);
		send(-16384, 0, 0, -16384, 0, 0, -16384);
		send(-16384, 0, 100, 0, 0, -100, -16384);
		send(-16384, 0, -100, 0, 0, 100, -16384);
		send(0, 0, 16384, 0, 0, 16384, 0);
		send(0, 0, -16384, 0, 0, -16384, 0);
		send(-32768, -32768, -32768, -32768, -32768, -32768, -32768);
		send(32767, 32767, 32767, 32767, 32767, 32767, 32767);
		send(32767, -32768, -32768, 32767, 32767, -32768, 32767);
		send(16384, 0, 1, 0, 0, 1, 16384);
		send(-16384, 0, 1, 0, 0, 1, -16384);
		send(0, 0, 0, 16384, 0, 0, 0);
		write_tolerance(1280);
		send(-16384, 0, 100, 0, 0, -100, -16384);
		send(16384, 0, 300, 0, 300, 300, 16384);
		send_random(300);
		write_tolerance(0);
		send(16384, 0, 1, 0, 0, 1, 16384);
		send_random(300);
		fork
			begin
				hold_off <= 1'b1;
				repeat (300) @(posedge clk);
				hold_off <= 1'b0;
			end
			send_random(200);
		join
		write_tolerance(2047);
		send_random(300);
		write_tolerance($urandom_range(2, 200));
		send_random(400);
		write_tolerance(1);
		send_random(300);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
